// ===== hw/rtl/dwg_pkg.sv =====
`default_nettype none

package dwg_pkg;

   // Coordinate format and weight precision.
   localparam int COORD_INT_BITS  = 10;
   localparam int COORD_FRAC_BITS = 16;
   localparam int WEIGHT_BITS     = 16;

   localparam int COORD_W = COORD_INT_BITS + COORD_FRAC_BITS;
   localparam int CELL_W  = 12;

   // |2r - 1| or |2r - 3| distance term, the root argument and the root.
   localparam int TWID_W = COORD_FRAC_BITS + 1;
   localparam int ARG_W  = 2 * COORD_FRAC_BITS + 2;
   localparam int ROOT_W = COORD_FRAC_BITS + 1;

   // 8*phi in Q.F fits below 8.0.
   localparam int PHI_W  = COORD_FRAC_BITS + 3;
   localparam int PROD_W = 2 * PHI_W;

   // Product scaled up by WEIGHT_BITS, then rounded down by 2F+6.
   localparam int WGT_SHIFT = 2 * COORD_FRAC_BITS + 6;
   localparam int SCALE_W   = PROD_W + WEIGHT_BITS + 1;

   // Stencil box geometry.
   localparam int TAPS   = 4;
   localparam int AXIS_W = 2;
   localparam int CELLS  = TAPS * TAPS;
   localparam int CNT_W  = 2 * AXIS_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef logic [TAPS-1:0][PHI_W-1:0] phi_set_type;

   typedef struct packed {
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
   } req_type;

   typedef struct packed {
      logic signed [CELL_W-1:0] cell_row;
      logic signed [CELL_W-1:0] cell_col;
      logic [WEIGHT_BITS-1:0]   weight;
      logic                     last;
   } rsp_type;

   // One marker's worth of work handed from the front to the back.
   typedef struct packed {
      logic [CELL_W-1:0] row_base;
      logic [CELL_W-1:0] col_base;
      phi_set_type       phi_x;
      phi_set_type       phi_y;
   } box_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_flags_type;

endpackage

`default_nettype wire

// ===== hw/rtl/dwg_front.sv =====
`default_nettype none

module dwg_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  dwg_pkg::req_type    req_pos,
   output logic                push,
   output dwg_pkg::box_type    push_box,
   input  dwg_pkg::q_flags_type q_flags
);
   import dwg_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SQUARE = 4'b0010,
      ST_ROOT   = 4'b0100,
      ST_PUSH   = 4'b1000
   } front_state_type;

   typedef struct packed {
      logic [ARG_W-1:0] v;
      logic [ARG_W-1:0] r;
   } sq_type;

   localparam logic [TWID_W-1:0] T_ONE     = TWID_W'(1) << COORD_FRAC_BITS;
   localparam logic [ARG_W-1:0]  ARG_TWO   = ARG_W'(1) << (2 * COORD_FRAC_BITS + 1);
   localparam logic [ARG_W-1:0]  BIT_START = ARG_W'(1) << (2 * COORD_FRAC_BITS);
   localparam logic [PHI_W-1:0]  P_ONE     = PHI_W'(1) << COORD_FRAC_BITS;
   localparam logic [PHI_W-1:0]  P_THREE   = PHI_W'(3) << COORD_FRAC_BITS;

   // Distance term |2f - 1|; all four taps of an axis share it.
   function automatic logic [TWID_W-1:0] dist_t(logic [COORD_FRAC_BITS-1:0] f);
      logic [TWID_W-1:0] two_f;
      two_f = {f, 1'b0};
      return f[COORD_FRAC_BITS-1] ? two_f - T_ONE : T_ONE - two_f;
   endfunction

   // One digit of the bit-by-bit integer square root.
   function automatic sq_type sq_step(sq_type cur, logic [ARG_W-1:0] b);
      sq_type         nxt;
      logic [ARG_W:0] trial;
      nxt   = cur;
      trial = {1'b0, cur.r} + {1'b0, b};
      if (b != '0) begin
         if ({1'b0, cur.v} >= trial) begin
            nxt.v = cur.v - trial[ARG_W-1:0];
            nxt.r = (cur.r >> 1) + b;
         end else begin
            nxt.r = cur.r >> 1;
         end
      end
      return nxt;
   endfunction

   // 8*phi for the four taps, leftmost first.
   function automatic phi_set_type axis_phi(logic [COORD_FRAC_BITS-1:0] f,
                                            logic [ROOT_W-1:0] r);
      phi_set_type      res;
      logic [PHI_W-1:0] two_f;
      logic [PHI_W-1:0] root;
      logic [PHI_W-1:0] base_hi;
      logic [PHI_W-1:0] base_lo;
      two_f   = PHI_W'({f, 1'b0});
      root    = PHI_W'(r);
      base_hi = P_THREE - two_f;
      base_lo = P_ONE + two_f;
      res[0]  = (root > base_hi) ? '0 : base_hi - root;
      res[1]  = base_hi + root;
      res[2]  = base_lo + root;
      res[3]  = (root > base_lo) ? '0 : base_lo - root;
      return res;
   endfunction

   front_state_type state_ff, state_in;
   logic [COORD_FRAC_BITS-1:0] frac_x_ff, frac_y_ff;
   logic [CELL_W-1:0]          base_x_ff, base_y_ff;
   logic [TWID_W-1:0]          tx_ff, ty_ff;
   sq_type                     x_ff, x_in, y_ff, y_in;
   logic [ARG_W-1:0]           bit_ff, bit_in;
   logic [ARG_W-1:0]           sq_x, sq_y;
   sq_type                     x_mid, y_mid;
   logic                       accept;

   assign busy   = (state_ff == ST_SQUARE) || (state_ff == ST_ROOT) ||
                   ((state_ff == ST_PUSH) && q_flags.full);
   assign accept = start && !busy;
   assign push   = (state_ff == ST_PUSH) && !q_flags.full;

   assign sq_x = tx_ff * tx_ff;
   assign sq_y = ty_ff * ty_ff;

   assign x_mid = sq_step(x_ff, bit_ff);
   assign y_mid = sq_step(y_ff, bit_ff);

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      bit_in   = bit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            x_in.v   = ARG_TWO - sq_x;
            x_in.r   = '0;
            y_in.v   = ARG_TWO - sq_y;
            y_in.r   = '0;
            bit_in   = BIT_START;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            x_in   = sq_step(x_mid, bit_ff >> 2);
            y_in   = sq_step(y_mid, bit_ff >> 2);
            bit_in = bit_ff >> 4;
            if ((bit_ff >> 4) == '0) state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!q_flags.full) state_in = accept ? ST_SQUARE : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      bit_ff <= bit_in;
      if (accept) begin
         frac_x_ff <= req_pos.pos_x[COORD_FRAC_BITS-1:0];
         frac_y_ff <= req_pos.pos_y[COORD_FRAC_BITS-1:0];
         base_x_ff <= CELL_W'(req_pos.pos_x[COORD_W-1:COORD_FRAC_BITS]) - CELL_W'(1);
         base_y_ff <= CELL_W'(req_pos.pos_y[COORD_W-1:COORD_FRAC_BITS]) - CELL_W'(1);
         tx_ff     <= dist_t(req_pos.pos_x[COORD_FRAC_BITS-1:0]);
         ty_ff     <= dist_t(req_pos.pos_y[COORD_FRAC_BITS-1:0]);
      end
   end

   always_comb begin
      push_box.row_base = base_x_ff;
      push_box.col_base = base_y_ff;
      push_box.phi_x    = axis_phi(frac_x_ff, x_ff.r[ROOT_W-1:0]);
      push_box.phi_y    = axis_phi(frac_y_ff, y_ff.r[ROOT_W-1:0]);
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dwg_queue.sv =====
`default_nettype none

module dwg_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dwg_pkg::box_type     push_box,
   input  logic                 pop,
   output dwg_pkg::box_type     pop_box,
   output dwg_pkg::q_flags_type q_flags
);
   import dwg_pkg::*;

   box_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;

   assign pop_box       = entry_ff[rd_ptr_ff];
   assign q_flags.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_flags.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_box;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         if (push && !pop) begin
            count_ff <= count_ff + (QPTR_W+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (QPTR_W+1)'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dwg_back.sv =====
`default_nettype none

module dwg_back (
   input  logic                 clock,
   input  logic                 reset,
   input  dwg_pkg::q_flags_type q_flags,
   input  dwg_pkg::box_type     pop_box,
   output logic                 pop,
   output logic                 rsp_strobe,
   output dwg_pkg::rsp_type     rsp_cell
);
   import dwg_pkg::*;

   localparam logic [CNT_W-1:0]       CELL_LAST = CNT_W'(CELLS - 1);
   localparam logic [SCALE_W-1:0]     ROUND_HALF = SCALE_W'(1) << (WGT_SHIFT - 1);
   localparam logic [SCALE_W-1:0]     MAX_WIDE = SCALE_W'((1 << WEIGHT_BITS) - 1);
   localparam logic [WEIGHT_BITS-1:0] MAX_WEIGHT = '1;

   box_type            cur_ff;
   logic               active_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [AXIS_W-1:0]  tap_a, tap_b;

   logic               s1_valid_ff;
   logic [PROD_W-1:0]  s1_prod_ff;
   logic [CELL_W-1:0]  s1_row_ff, s1_col_ff;
   logic               s1_last_ff;

   logic [SCALE_W-1:0] scaled;
   logic [SCALE_W-1:0] w_full;

   logic               strobe_ff;
   rsp_type            out_ff, out_in;

   assign pop   = !q_flags.empty && (!active_ff || (cnt_ff == CELL_LAST));
   assign tap_a = cnt_ff[CNT_W-1:AXIS_W];
   assign tap_b = cnt_ff[AXIS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
      end else if (pop) begin
         active_ff <= 1'b1;
         cnt_ff    <= '0;
      end else if (active_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CELL_LAST) active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= pop_box;
   end

   // Stage one: product of the two tap weights and the cell address.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_prod_ff <= PROD_W'(cur_ff.phi_x[tap_a]) * PROD_W'(cur_ff.phi_y[tap_b]);
      s1_row_ff  <= cur_ff.row_base + CELL_W'(tap_a);
      s1_col_ff  <= cur_ff.col_base + CELL_W'(tap_b);
      s1_last_ff <= (cnt_ff == CELL_LAST);
   end

   // Stage two: round to nearest, ties up, then saturate.
   assign scaled = {1'b0, s1_prod_ff, {WEIGHT_BITS{1'b0}}} + ROUND_HALF;
   assign w_full = scaled >> WGT_SHIFT;

   always_comb begin
      out_in.cell_row = signed'(s1_row_ff);
      out_in.cell_col = signed'(s1_col_ff);
      out_in.weight   = (w_full > MAX_WIDE) ? MAX_WEIGHT : w_full[WEIGHT_BITS-1:0];
      out_in.last     = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_cell   = out_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ib_delta_weight_generator.sv =====
`default_nettype none

// Four-point delta weight generator for immersed-boundary markers.
// A marker position (pos_x, pos_y) is offered on req_pos with start; it is
// taken at a rising edge where start is high and busy is low. For every
// marker the block returns sixteen beats on rsp_cell, one per cell of the
// 4x4 stencil box in row-major order, each marked by rsp_strobe for one
// cycle. A beat carries the cell's row and column and the weight
// phi(x-row)*phi(y-col) in unsigned Q0.16; last flags the sixteenth beat.
// The receiver cannot hold beats off, so the block never stalls its output.
// The front computes one square root per axis, two root bits per cycle;
// a marker passes through its square, root and push states from the
// accepting edge to the edge that writes it into a two-entry queue, and
// waits in the push state while the queue is full. The back issues one
// product per cycle through a two-stage multiply and round pipeline, and
// the beats of one box follow on consecutive cycles. The sustained marker
// rate is set by the back's single multiplier; busy drops again as soon
// as the front has handed its marker to the queue. Reset is synchronous
// and empties the queue and both pipelines; no beats are produced until
// a new marker.

module ib_delta_weight_generator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dwg_pkg::req_type req_pos,
   output logic             rsp_strobe,
   output dwg_pkg::rsp_type rsp_cell
);
   import dwg_pkg::*;

   logic        push, pop;
   box_type     push_box, pop_box;
   q_flags_type q_flags;

   dwg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_pos  (req_pos),
      .push     (push),
      .push_box (push_box),
      .q_flags  (q_flags)
   );

   dwg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_box (push_box),
      .pop      (pop),
      .pop_box  (pop_box),
      .q_flags  (q_flags)
   );

   dwg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_flags    (q_flags),
      .pop_box    (pop_box),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_cell   (rsp_cell)
   );

   // The front never writes a full queue.
   assert property (@(posedge clock) disable iff (reset) push |-> !q_flags.full)
      else $error("push into full queue");

   // The back never reads an empty queue.
   assert property (@(posedge clock) disable iff (reset) pop |-> !q_flags.empty)
      else $error("pop from empty queue");

   // Beats of one box come on consecutive cycles.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_strobe && !rsp_cell.last |=> rsp_strobe)
      else $error("gap inside a stencil box");

   // Columns advance by one inside a row of the box.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_strobe && $past(rsp_strobe) && !$past(rsp_cell.last) &&
                    (rsp_cell.cell_row == $past(rsp_cell.cell_row)) |->
                    (rsp_cell.cell_col == $past(rsp_cell.cell_col) + 12'sd1))
      else $error("column sequence broken");

endmodule

`default_nettype wire
